>>> src/krt_pkg.sv
// keyed record table: shared constants, operation and status codes, and the
// command/status structs between the controller and the datapath
// no dependencies
package krt_pkg;

  localparam int TABLE_DEPTH  = 128;
  localparam int PAYLOAD_BITS = 64;

  localparam int IDX_W     = $clog2(TABLE_DEPTH);
  localparam int CNT_W     = $clog2(TABLE_DEPTH + 1);
  localparam int CMP_W     = CNT_W + 1;
  localparam int KEY_W     = 32;
  localparam int FUNC_W    = 2;
  localparam int STAT_W    = 2;
  localparam int OUT_PAY_W = 64;
  localparam int OUT_CNT_W = 8;

  localparam logic [FUNC_W-1:0] FN_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FN_LOOKUP = 2'd1;
  localparam logic [FUNC_W-1:0] FN_UPDATE = 2'd2;
  localparam logic [FUNC_W-1:0] FN_DELETE = 2'd3;

  localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
  localparam logic [STAT_W-1:0] ST_DUP  = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL = 2'd2;
  localparam logic [STAT_W-1:0] ST_MISS = 2'd3;

  typedef struct packed {
    logic              start;     // latch request, clear index
    logic              rd_cur;    // read entry at index
    logic              rd_next;   // read entry at index + 1
    logic              rd_skip;   // read entry at index + 2
    logic              idx_inc;
    logic              wr_ins;    // append request record at count
    logic              wr_upd;    // overwrite payload at index
    logic              wr_shift;  // move read record down to index
    logic              cnt_dec;
    logic              st_set;
    logic [STAT_W-1:0] st_code;
    logic              pay_take;  // result payload from read data
    logic              res_load;
  } dp_cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              full;
    logic              cnt_zero;
    logic              key_hit;
    logic              idx_last;    // index + 1 >= count
    logic              shift_last;  // index + 2 >= count
    logic              out_free;
  } dp_stat_t;

endpackage

>>> src/krt_datapath.sv
// keyed record table datapath: key and payload memories, request and index
// registers, record count and output register
// depends on krt_pkg
module krt_datapath
  import krt_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  dp_cmd_t              cmd,
  output dp_stat_t             stat,
  input  logic [FUNC_W-1:0]    req_func,
  input  logic [KEY_W-1:0]     req_key,
  input  logic [OUT_PAY_W-1:0] req_payload,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [STAT_W-1:0]    out_status,
  output logic [OUT_PAY_W-1:0] out_payload,
  output logic [OUT_CNT_W-1:0] out_count
);

  logic [KEY_W-1:0]        key_mem [TABLE_DEPTH];
  logic [PAYLOAD_BITS-1:0] pay_mem [TABLE_DEPTH];

  logic [FUNC_W-1:0]       func_r;
  logic [KEY_W-1:0]        key_r;
  logic [PAYLOAD_BITS-1:0] pay_r;
  logic [IDX_W-1:0]        idx_r;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic [KEY_W-1:0]        rd_key_r;
  logic [PAYLOAD_BITS-1:0] rd_pay_r;
  logic [STAT_W-1:0]       pend_status_r;
  logic [PAYLOAD_BITS-1:0] pend_pay_r;
  logic                    out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0]       out_status_r;
  logic [OUT_PAY_W-1:0]    out_pay_r;
  logic [OUT_CNT_W-1:0]    out_cnt_r;

  logic [IDX_W-1:0]        rd_addr;
  logic [IDX_W-1:0]        wr_addr;
  logic                    key_we, pay_we;
  logic [KEY_W-1:0]        key_wdata;
  logic [PAYLOAD_BITS-1:0] pay_wdata;
  logic [CMP_W-1:0]        idx_ext, cnt_ext;

  assign idx_ext = CMP_W'(idx_r);
  assign cnt_ext = CMP_W'(cnt_r);

  always_comb begin
    if (cmd.rd_skip) begin
      rd_addr = idx_r + IDX_W'(2);
    end else if (cmd.rd_next) begin
      rd_addr = idx_r + IDX_W'(1);
    end else begin
      rd_addr = idx_r;
    end
  end

  // an append always lands below the depth, so the count fits the index
  assign wr_addr   = cmd.wr_ins ? cnt_r[IDX_W-1:0] : idx_r;
  assign key_we    = cmd.wr_ins | cmd.wr_shift;
  assign pay_we    = cmd.wr_ins | cmd.wr_upd | cmd.wr_shift;
  assign key_wdata = cmd.wr_shift ? rd_key_r : key_r;
  assign pay_wdata = cmd.wr_shift ? rd_pay_r : pay_r;

  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[wr_addr] <= key_wdata;
    end
    if (pay_we) begin
      pay_mem[wr_addr] <= pay_wdata;
    end
    if (cmd.rd_cur | cmd.rd_next | cmd.rd_skip) begin
      rd_key_r <= key_mem[rd_addr];
      rd_pay_r <= pay_mem[rd_addr];
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.wr_ins) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (cmd.cnt_dec) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.res_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      func_r <= req_func;
      key_r  <= req_key;
      pay_r  <= req_payload[PAYLOAD_BITS-1:0];
      idx_r  <= '0;
    end else if (cmd.idx_inc) begin
      idx_r  <= idx_r + IDX_W'(1);
    end
    if (cmd.st_set) begin
      pend_status_r <= cmd.st_code;
      pend_pay_r    <= cmd.pay_take ? rd_pay_r : '0;
    end
    if (cmd.res_load) begin
      out_status_r <= pend_status_r;
      out_pay_r    <= OUT_PAY_W'(pend_pay_r);
      out_cnt_r    <= OUT_CNT_W'(cnt_r);
    end
  end

  assign stat.func       = func_r;
  assign stat.full       = cnt_r >= CNT_W'(TABLE_DEPTH);
  assign stat.cnt_zero   = cnt_r == '0;
  assign stat.key_hit    = rd_key_r == key_r;
  assign stat.idx_last   = (idx_ext + CMP_W'(1)) >= cnt_ext;
  assign stat.shift_last = (idx_ext + CMP_W'(2)) >= cnt_ext;
  assign stat.out_free   = !out_valid_r || out_ready;

  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_payload = out_pay_r;
  assign out_count   = out_cnt_r;

  a_cnt_bound : assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(TABLE_DEPTH))
    else $error("record count above table depth");

  a_ins_room : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_ins |-> cnt_r < CNT_W'(TABLE_DEPTH))
    else $error("append into a full table");

  a_shift_src : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_shift |-> (idx_ext + CMP_W'(1)) < cnt_ext)
    else $error("shift move past the last record");

  a_dec_nonzero : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cnt_dec |-> cnt_r != '0)
    else $error("record count underflow");

  a_res_held : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.res_load |-> stat.out_free)
    else $error("result loaded over an untaken result");

endmodule

>>> src/krt_ctrl.sv
// keyed record table controller: sequences the linear key search, the
// append, overwrite and delete shift, and hands the result to the output
// depends on krt_pkg
module krt_ctrl
  import krt_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHK   = 3'd1;
  localparam logic [2:0] S_CMP   = 3'd2;
  localparam logic [2:0] S_SHIFT = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0] state_r, state_nxt;

  assign in_ready = state_r == S_IDLE;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.start = 1'b1;
          state_nxt = S_CHK;
        end
      end
      S_CHK: begin
        if (stat.func == FN_INSERT && stat.full) begin
          cmd.st_set  = 1'b1;
          cmd.st_code = ST_FULL;
          state_nxt   = S_DONE;
        end else if (stat.cnt_zero) begin
          cmd.st_set = 1'b1;
          if (stat.func == FN_INSERT) begin
            cmd.wr_ins  = 1'b1;
            cmd.st_code = ST_OK;
          end else begin
            cmd.st_code = ST_MISS;
          end
          state_nxt = S_DONE;
        end else begin
          cmd.rd_cur = 1'b1;
          state_nxt  = S_CMP;
        end
      end
      S_CMP: begin
        if (stat.key_hit) begin
          cmd.st_set = 1'b1;
          state_nxt  = S_DONE;
          case (stat.func)
            FN_INSERT: cmd.st_code = ST_DUP;
            FN_LOOKUP: begin
              cmd.st_code  = ST_OK;
              cmd.pay_take = 1'b1;
            end
            FN_UPDATE: begin
              cmd.st_code = ST_OK;
              cmd.wr_upd  = 1'b1;
            end
            default: begin
              cmd.st_code = ST_OK;
              if (stat.idx_last) begin
                cmd.cnt_dec = 1'b1;
              end else begin
                cmd.st_set  = 1'b0;
                cmd.rd_next = 1'b1;
                state_nxt   = S_SHIFT;
              end
            end
          endcase
        end else if (!stat.idx_last) begin
          // fetch the next entry while this one is compared
          cmd.rd_next = 1'b1;
          cmd.idx_inc = 1'b1;
        end else begin
          cmd.st_set = 1'b1;
          if (stat.func == FN_INSERT) begin
            cmd.wr_ins  = 1'b1;
            cmd.st_code = ST_OK;
          end else begin
            cmd.st_code = ST_MISS;
          end
          state_nxt = S_DONE;
        end
      end
      S_SHIFT: begin
        // move the fetched record down one place, fetch the one after it
        cmd.wr_shift = 1'b1;
        cmd.idx_inc  = 1'b1;
        if (stat.shift_last) begin
          cmd.cnt_dec = 1'b1;
          cmd.st_set  = 1'b1;
          cmd.st_code = ST_OK;
          state_nxt   = S_DONE;
        end else begin
          cmd.rd_skip = 1'b1;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.res_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_start_idle : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.start |-> state_r == S_IDLE)
    else $error("request latched outside idle");

  a_load_idle : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.res_load |=> state_r == S_IDLE)
    else $error("result loaded without returning to idle");

  a_one_write : assert property (@(posedge clk) disable iff (!rst_n)
    $countones({cmd.wr_ins, cmd.wr_upd, cmd.wr_shift}) <= 1)
    else $error("conflicting table writes");

endmodule

>>> src/keyed_record_table_unit.sv
// keyed record table top level: unsorted key/payload table with insert,
// lookup, update and order-keeping delete
// depends on krt_pkg, krt_ctrl, krt_datapath
//
//  channel  | group                    | contents
//  ---------+--------------------------+--------------------------------------
//  request  | in_tvalid/tready/tuser/  | tuser: func; tdata: key, payload_in
//           | tdata                    |
//  result   | out_tvalid/tready/tuser/ | tuser: status; tdata: payload_out,
//           | tdata                    | entry_count
//
//  a request searches the stored entries in order up to the first match
//  (all of them on a miss or a new insert); a delete then moves each later
//  record down one place, the memories having one read and one write port
//  one new request is taken after the previous result is in the output
//  register, which holds it while out_tready is low; rst_n (synchronous)
//  clears the record count, out_tvalid and state, with no clearing pass
module keyed_record_table_unit
  import krt_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [1:0]   in_tuser,   // [1:0] func
  input  logic [95:0]  in_tdata,   // [31:0] key, [95:32] payload_in
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [1:0]   out_tuser,  // [1:0] status
  output logic [71:0]  out_tdata   // [63:0] payload_out, [71:64] entry_count
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  logic [OUT_PAY_W-1:0] res_payload;
  logic [OUT_CNT_W-1:0] res_count;

  krt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  krt_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .stat        (stat),
    .req_func    (in_tuser[FUNC_W-1:0]),
    .req_key     (in_tdata[KEY_W-1:0]),
    .req_payload (in_tdata[KEY_W +: OUT_PAY_W]),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_status  (out_tuser),
    .out_payload (res_payload),
    .out_count   (res_count)
  );

  assign out_tdata = {res_count, res_payload};

endmodule

>>> tb/sv/tb_keyed_record_table_unit.sv
// self-checking testbench for keyed_record_table_unit: random bursty requests against a
// behavioural copy of the record table, results compared field by field in order
// depends on krt_pkg and keyed_record_table_unit
`timescale 1ns / 100ps

module tb_keyed_record_table_unit;
  import krt_pkg::*;

  localparam int IDLE_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 300;
  localparam int HOLD_CYCLES = 600;
  localparam int POOL_SIZE = 24;

  typedef struct {
    logic [FUNC_W-1:0] func;
    logic [KEY_W-1:0]  key;
    logic [63:0]       payload;
    bit                wait_idle;  // hold back until every result is back
  } table_request_t;

  typedef struct {
    logic [STAT_W-1:0]    status;
    logic [OUT_PAY_W-1:0] payload;
    logic [OUT_CNT_W-1:0] count;
  } table_result_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [1:0]   in_tuser = '0;   // [1:0] func
  logic [95:0]  in_tdata = '0;   // [31:0] key, [95:32] payload_in
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [1:0]   out_tuser;       // [1:0] status
  logic [71:0]  out_tdata;       // [63:0] payload_out, [71:64] entry_count

  keyed_record_table_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tuser   (in_tuser),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tuser  (out_tuser),
    .out_tdata  (out_tdata)
  );

  always #10 clk = ~clk;

  // shadow copy of the table
  logic [KEY_W-1:0]        shadow_keys [TABLE_DEPTH];
  logic [PAYLOAD_BITS-1:0] shadow_payloads [TABLE_DEPTH];
  int                      shadow_count = 0;

  table_request_t request_queue[$];
  table_result_t  expected_results[$];
  logic [KEY_W-1:0] key_pool [POOL_SIZE];

  int  mismatches = 0;
  int  results_seen = 0;
  int  idle_cycles = 0;
  bit  in_taken = 0;
  int  burst_left = 0;
  int  gap_left = 0;
  int  hold_left = 0;
  bit  hold_done = 0;
  int  mode_left = 0;
  int  rx_mode = 0;
  int  rx_phase = 0;

  function automatic table_result_t apply_request(input logic [FUNC_W-1:0] func,
                                                  input logic [KEY_W-1:0] key,
                                                  input logic [63:0] payload);
    table_result_t           r;
    int                      hit;
    logic [PAYLOAD_BITS-1:0] pl;
    pl = payload[PAYLOAD_BITS-1:0];
    r.status = ST_OK;
    r.payload = '0;
    hit = -1;
    for (int i = 0; i < shadow_count; i++)
      if (hit < 0 && shadow_keys[i] == key) hit = i;
    if (func == FN_INSERT) begin
      // full is tested ahead of duplicate
      if (shadow_count >= TABLE_DEPTH) r.status = ST_FULL;
      else if (hit >= 0) r.status = ST_DUP;
      else begin
        shadow_keys[shadow_count] = key;
        shadow_payloads[shadow_count] = pl;
        shadow_count++;
      end
    end else if (hit < 0) begin
      r.status = ST_MISS;
    end else if (func == FN_LOOKUP) begin
      r.payload = OUT_PAY_W'(shadow_payloads[hit]);
    end else if (func == FN_UPDATE) begin
      shadow_payloads[hit] = pl;
    end else begin
      for (int j = hit; j + 1 < shadow_count; j++) begin
        shadow_keys[j] = shadow_keys[j + 1];
        shadow_payloads[j] = shadow_payloads[j + 1];
      end
      shadow_count--;
    end
    r.count = OUT_CNT_W'(shadow_count);
    return r;
  endfunction

  function automatic logic [63:0] rand_payload();
    return {$urandom, $urandom};
  endfunction

  task automatic push_request(input logic [FUNC_W-1:0] func, input logic [KEY_W-1:0] key,
                              input logic [63:0] payload, input bit wait_idle = 0);
    table_request_t req;
    req.func = func;
    req.key = key;
    req.payload = payload;
    req.wait_idle = wait_idle;
    request_queue.push_back(req);
  endtask

  // input and output transfers, checked at the rising edge
  always @(posedge clk) begin
    table_result_t exp_res;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        expected_results.push_back(apply_request(in_tuser, in_tdata[31:0], in_tdata[95:32]));
        in_taken = 1;
      end
      if (out_tvalid && out_tready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: status %0d payload %h count %0d",
                     out_tuser, out_tdata[63:0], out_tdata[71:64]);
        end else begin
          exp_res = expected_results.pop_front();
          if (out_tuser !== exp_res.status || out_tdata[63:0] !== exp_res.payload ||
              out_tdata[71:64] !== exp_res.count) begin
            mismatches++;
            if (mismatches <= 10)
              $display("result %0d mismatch: status exp %0d got %0d, payload exp %h got %h, count exp %0d got %0d",
                       results_seen, exp_res.status, out_tuser, exp_res.payload,
                       out_tdata[63:0], exp_res.count, out_tdata[71:64]);
          end
        end
      end
    end
  end

  // request driver: bursts of transfers with random gaps
  always @(negedge clk) begin
    table_request_t req;
    int             r;
    if (rst_n && !(in_tvalid && !in_taken)) begin
      in_taken = 0;
      if (gap_left > 0) begin
        gap_left--;
        in_tvalid <= 1'b0;
      end else if (request_queue.size() > 0 &&
                   (!request_queue[0].wait_idle || expected_results.size() == 0)) begin
        req = request_queue.pop_front();
        in_tuser <= req.func;
        in_tdata <= {req.payload, req.key};
        in_tvalid <= 1'b1;
        if (burst_left > 0) burst_left--;
        if (burst_left == 0) begin
          r = $urandom_range(0, 9);
          if (r < 2) begin
            burst_left = $urandom_range(30, 60);
            gap_left = 0;
          end else begin
            burst_left = $urandom_range(1, 8);
            gap_left = $urandom_range(1, 12);
          end
        end
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // result receiver: random stall patterns that change over the run, plus one long hold-off
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (!hold_done && results_seen >= 60) begin
      hold_done = 1;
      hold_left = HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      if (mode_left <= 0) begin
        rx_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 120);
      end
      mode_left--;
      rx_phase++;
      case (rx_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= 1'($urandom_range(0, 1));
        2: out_tready <= ($urandom_range(0, 3) == 0);
        default: out_tready <= (rx_phase % 3 != 0);
      endcase
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    int               r;
    logic [KEY_W-1:0] fill_base;
    logic [KEY_W-1:0] k;

    key_pool[0] = 32'h8000_0000;
    key_pool[1] = 32'h7FFF_FFFF;
    key_pool[2] = 32'h0000_0000;
    key_pool[3] = 32'hFFFF_FFFF;
    key_pool[4] = 32'h0000_0001;
    key_pool[5] = 32'h8000_0001;
    for (int i = 6; i < POOL_SIZE; i++) key_pool[i] = $urandom;

    // directed: empty table, key and payload extremes, duplicate, shifts on delete
    push_request(FN_LOOKUP, 32'h0000_0000, rand_payload());
    push_request(FN_UPDATE, 32'h8000_0000, rand_payload());
    push_request(FN_DELETE, 32'h7FFF_FFFF, rand_payload());
    push_request(FN_INSERT, 32'h8000_0000, 64'hFFFF_FFFF_FFFF_FFFF);
    push_request(FN_INSERT, 32'h7FFF_FFFF, 64'h0);
    push_request(FN_INSERT, 32'h0000_0000, 64'hAAAA_AAAA_AAAA_AAAA);
    push_request(FN_INSERT, 32'hFFFF_FFFF, 64'h5555_5555_5555_5555);
    push_request(FN_INSERT, 32'h7FFF_FFFF, rand_payload());
    push_request(FN_LOOKUP, 32'h8000_0000, rand_payload());
    push_request(FN_LOOKUP, 32'hFFFF_FFFF, rand_payload());
    push_request(FN_LOOKUP, 32'h0000_0001, rand_payload());
    push_request(FN_UPDATE, 32'h0000_0000, 64'hFFFF_FFFF_FFFF_FFFF);
    push_request(FN_LOOKUP, 32'h0000_0000, rand_payload());
    push_request(FN_UPDATE, 32'h8000_0000, 64'h0);
    push_request(FN_LOOKUP, 32'h8000_0000, rand_payload());
    push_request(FN_DELETE, 32'h7FFF_FFFF, rand_payload());
    push_request(FN_LOOKUP, 32'hFFFF_FFFF, rand_payload());
    push_request(FN_DELETE, 32'h8000_0000, rand_payload());
    push_request(FN_DELETE, 32'hFFFF_FFFF, rand_payload());
    push_request(FN_LOOKUP, 32'h0000_0000, rand_payload());
    push_request(FN_DELETE, 32'h0000_0000, rand_payload());
    push_request(FN_DELETE, 32'h0000_0000, rand_payload());
    push_request(FN_INSERT, 32'h0000_0001, rand_payload());

    // mixed traffic on a small key pool so hits are common, some noise keys
    for (int i = 0; i < 140; i++) begin
      k = ($urandom_range(0, 9) == 0) ? $urandom : key_pool[$urandom_range(0, POOL_SIZE - 1)];
      r = $urandom_range(0, 99);
      if (r < 35) push_request(FN_INSERT, k, rand_payload());
      else if (r < 60) push_request(FN_LOOKUP, k, rand_payload());
      else if (r < 80) push_request(FN_UPDATE, k, rand_payload());
      else push_request(FN_DELETE, k, rand_payload());
    end

    // fill with distinct keys, enough to reach a full table whatever was left
    fill_base = $urandom;
    for (int i = 0; i < 150; i++)
      push_request(FN_INSERT, fill_base + i, rand_payload(), i == 0);

    // traffic around the full mark: full beats duplicate, deep searches
    for (int i = 0; i < 40; i++) begin
      k = fill_base + $urandom_range(0, 149);
      r = $urandom_range(0, 99);
      if (r < 20) push_request(FN_INSERT, k, rand_payload());
      else if (r < 35) push_request(FN_INSERT, $urandom, rand_payload());
      else if (r < 60) push_request(FN_LOOKUP, k, rand_payload());
      else if (r < 85) push_request(FN_UPDATE, k, rand_payload());
      else push_request(FN_DELETE, k, rand_payload());
    end

    // drain part of the table with long shifts
    for (int i = 0; i < 45; i++) begin
      r = $urandom_range(0, 99);
      if (r < 70)
        push_request(FN_DELETE, fill_base + $urandom_range(0, 149), rand_payload(), i == 0);
      else if (r < 85)
        push_request(FN_LOOKUP, key_pool[$urandom_range(0, POOL_SIZE - 1)], rand_payload());
      else
        push_request(FN_INSERT, key_pool[$urandom_range(0, POOL_SIZE - 1)], rand_payload());
    end

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    while (request_queue.size() > 0 || in_tvalid || expected_results.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
